FILE: rtl/fbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types and constants of the frustum box cull unit.
// ----------------------------------------------------------------------------
package fbc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int PLANE_W    = 64;
    localparam int NORM_W     = 16;
    localparam int NORM_FRAC  = 14;
    localparam int OFFSET_LSB = 48;
    localparam int CFG_IDX_W  = 3;

    typedef logic [PLANE_W-1:0] t_plane;
    typedef logic [NUM_PLANES-1:0][PLANE_W-1:0] t_plane_arr;

    typedef enum logic [CFG_IDX_W-1:0] {
        PLANE_NEAR   = 3'd0,
        PLANE_FAR    = 3'd1,
        PLANE_LEFT   = 3'd2,
        PLANE_RIGHT  = 3'd3,
        PLANE_TOP    = 3'd4,
        PLANE_BOTTOM = 3'd5
    } t_plane_idx;

endpackage
`default_nettype wire

FILE: rtl/fbc_plane_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_plane_regs
// Six frustum plane registers written through the configuration channel.
// ----------------------------------------------------------------------------
module fbc_plane_regs (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_valid,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fbc_pkg::PLANE_W-1:0]   i_cfg_data,
    output fbc_pkg::t_plane_arr             o_planes
);
    import fbc_pkg::*;

    t_plane r_planes [NUM_PLANES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < NUM_PLANES; p++) begin
                r_planes[p] <= '0;
            end
        end else if (i_cfg_valid) begin
            unique case (t_plane_idx'(i_cfg_index))
                PLANE_NEAR:   r_planes[0] <= i_cfg_data;
                PLANE_FAR:    r_planes[1] <= i_cfg_data;
                PLANE_LEFT:   r_planes[2] <= i_cfg_data;
                PLANE_RIGHT:  r_planes[3] <= i_cfg_data;
                PLANE_TOP:    r_planes[4] <= i_cfg_data;
                PLANE_BOTTOM: r_planes[5] <= i_cfg_data;
                // out-of-range index is dropped
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            o_planes[p] = r_planes[p];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fbc_plane_dot.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_plane_dot
// Two stages: all plane products, then per-plane signed sums of
// n.c + e.|n| - d, plus the sum of squared extents.
// ----------------------------------------------------------------------------
module fbc_plane_dot #(
    parameter int COORD_WIDTH = 16,
    parameter int SUM_W       = 35
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_vld,
    input  wire logic [2:0][COORD_WIDTH-1:0]           i_center,
    input  wire logic [2:0][COORD_WIDTH-2:0]           i_extent,
    input  wire fbc_pkg::t_plane_arr                   i_planes,
    output logic                                       o_vld,
    output logic [2*COORD_WIDTH-1:0]                   o_sq,
    output logic [fbc_pkg::NUM_PLANES-1:0][SUM_W-1:0]  o_sums
);
    import fbc_pkg::*;

    localparam int PC_W = COORD_WIDTH + NORM_W;
    localparam int PE_W = COORD_WIDTH + NORM_W - 1;
    localparam int SQ_W = 2 * (COORD_WIDTH - 1);

    logic signed [NORM_W-1:0]  w_n   [NUM_PLANES][3];
    logic        [NORM_W-1:0]  w_an  [NUM_PLANES][3];
    logic signed [NORM_W-1:0]  w_d   [NUM_PLANES];

    logic                      r_vld1;
    logic signed [PC_W-1:0]    r_pc  [NUM_PLANES][3];
    logic        [PE_W-1:0]    r_pe  [NUM_PLANES][3];
    logic        [SQ_W-1:0]    r_esq [3];

    logic signed [SUM_W-1:0]   n_sum [NUM_PLANES];
    logic        [2*COORD_WIDTH-1:0] n_sq;

    logic                      r_vld2;
    logic signed [SUM_W-1:0]   r_sum [NUM_PLANES];
    logic        [2*COORD_WIDTH-1:0] r_sq;

    // plane fields and absolute normal components
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < 3; a++) begin
                w_n[p][a]  = $signed(i_planes[p][NORM_W*a +: NORM_W]);
                // most negative component maps to 2^15, which still fits
                w_an[p][a] = w_n[p][a][NORM_W-1] ? (NORM_W'(0) - w_n[p][a])
                                                 : w_n[p][a];
            end
            w_d[p] = $signed(i_planes[p][OFFSET_LSB +: NORM_W]);
        end
    end

    // stage 1: products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
        end else begin
            r_vld1 <= i_vld;
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < 3; a++) begin
                r_pc[p][a] <= w_n[p][a] * $signed(i_center[a]);
                r_pe[p][a] <= w_an[p][a] * i_extent[a];
            end
        end
        for (int a = 0; a < 3; a++) begin
            r_esq[a] <= i_extent[a] * i_extent[a];
        end
    end

    // stage 2: per-plane sums
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            n_sum[p] = -$signed({w_d[p], {NORM_FRAC{1'b0}}});
            for (int a = 0; a < 3; a++) begin
                n_sum[p] = n_sum[p] + r_pc[p][a] + $signed({1'b0, r_pe[p][a]});
            end
        end
        n_sq = (2*COORD_WIDTH)'(r_esq[0]) + (2*COORD_WIDTH)'(r_esq[1])
             + (2*COORD_WIDTH)'(r_esq[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
        end else begin
            r_vld2 <= r_vld1;
        end
        for (int p = 0; p < NUM_PLANES; p++) begin
            r_sum[p] <= n_sum[p];
        end
        r_sq <= n_sq;
    end

    always_comb begin
        o_vld = r_vld2;
        o_sq  = r_sq;
        for (int p = 0; p < NUM_PLANES; p++) begin
            o_sums[p] = r_sum[p];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/fbc_isqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_isqrt_pipe
// Floor square root, one root bit per register stage, with a sideband
// word that travels alongside.
// ----------------------------------------------------------------------------
module fbc_isqrt_pipe #(
    parameter int OUT_W  = 16,
    parameter int SIDE_W = 210
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_vld,
    input  wire logic [2*OUT_W-1:0]   i_radicand,
    input  wire logic [SIDE_W-1:0]    i_side,
    output logic                      o_vld,
    output logic [OUT_W-1:0]          o_root,
    output logic [SIDE_W-1:0]         o_side
);

    logic               r_vld  [OUT_W];
    logic [OUT_W-1:0]   r_root [OUT_W];
    logic [SIDE_W-1:0]  r_side [OUT_W];
    logic [OUT_W-1:0]   r_rem  [OUT_W-1];
    logic [2*OUT_W-1:0] r_rad  [OUT_W-1];

    logic               n_vld  [OUT_W];
    logic [OUT_W-1:0]   n_root [OUT_W];
    logic [SIDE_W-1:0]  n_side [OUT_W];
    logic [OUT_W-1:0]   n_rem  [OUT_W];
    logic [2*OUT_W-1:0] n_rad  [OUT_W];

    for (genvar s = 0; s < OUT_W; s++) begin : g_stage
        logic               w_pvld;
        logic [OUT_W-1:0]   w_proot;
        logic [OUT_W-1:0]   w_prem;
        logic [2*OUT_W-1:0] w_prad;
        logic [SIDE_W-1:0]  w_pside;
        logic [OUT_W+1:0]   w_trem;
        logic [OUT_W+1:0]   w_trial;
        logic [OUT_W+1:0]   w_diff;
        logic               w_ge;

        if (s == 0) begin : g_first
            assign w_pvld  = i_vld;
            assign w_proot = '0;
            assign w_prem  = '0;
            assign w_prad  = i_radicand;
            assign w_pside = i_side;
        end else begin : g_next
            assign w_pvld  = r_vld[s-1];
            assign w_proot = r_root[s-1];
            assign w_prem  = r_rem[s-1];
            assign w_prad  = r_rad[s-1];
            assign w_pside = r_side[s-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign w_trem  = {w_prem, w_prad[2*OUT_W-1 -: 2]};
        assign w_trial = {w_proot, 2'b01};
        assign w_ge    = (w_trem >= w_trial);
        assign w_diff  = w_trem - w_trial;

        assign n_vld[s]  = w_pvld;
        assign n_root[s] = {w_proot[OUT_W-2:0], w_ge};
        assign n_side[s] = w_pside;
        assign n_rem[s]  = w_ge ? w_diff[OUT_W-1:0] : w_trem[OUT_W-1:0];
        assign n_rad[s]  = {w_prad[2*OUT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < OUT_W; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else begin
            for (int s = 0; s < OUT_W; s++) begin
                r_vld[s] <= n_vld[s];
            end
        end
        for (int s = 0; s < OUT_W; s++) begin
            r_root[s] <= n_root[s];
            r_side[s] <= n_side[s];
        end
        // the last stage needs no remainder
        for (int s = 0; s < OUT_W-1; s++) begin
            r_rem[s] <= n_rem[s];
            r_rad[s] <= n_rad[s];
        end
    end

    assign o_vld  = r_vld[OUT_W-1];
    assign o_root = r_root[OUT_W-1];
    assign o_side = r_side[OUT_W-1];

endmodule
`default_nettype wire

FILE: rtl/frustum_box_cull_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_cull_unit
// Pipeline: input register, two product/sum stages, one square-root stage
// per root bit and an output register lie between the item and its result.
// Throughput: one item per cycle; busy stays low and results cannot stall.
// Reset: all planes clear to zero, so every box reads visible until written.
// ----------------------------------------------------------------------------
module frustum_box_cull_unit #(
    parameter int COORD_WIDTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_x,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_y,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_z,
    input  wire logic [COORD_WIDTH-2:0]        i_extent_x,
    input  wire logic [COORD_WIDTH-2:0]        i_extent_y,
    input  wire logic [COORD_WIDTH-2:0]        i_extent_z,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [fbc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [fbc_pkg::PLANE_W-1:0]   i_cfg_data,
    output logic                               o_result_valid,
    output logic                               o_visible
);
    import fbc_pkg::*;

    localparam int SUM_W  = (COORD_WIDTH + 19 > 32) ? COORD_WIDTH + 19 : 32;
    localparam int SIDE_W = NUM_PLANES * SUM_W;

    logic                              r_vld0;
    logic [2:0][COORD_WIDTH-1:0]       r_center;
    logic [2:0][COORD_WIDTH-2:0]       r_extent;

    t_plane_arr                        w_planes;
    logic                              w_dot_vld;
    logic [2*COORD_WIDTH-1:0]          w_sq;
    logic [NUM_PLANES-1:0][SUM_W-1:0]  w_sums;

    logic                              w_sq_vld;
    logic [COORD_WIDTH-1:0]            w_root;
    logic [NUM_PLANES-1:0][SUM_W-1:0]  w_dly_sums;

    logic signed [SUM_W:0]             w_tot  [NUM_PLANES];
    logic [NUM_PLANES-1:0]             w_pass;

    logic                              r_out_vld;
    logic                              r_visible;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else begin
            r_vld0 <= start;
        end
        r_center[0] <= i_center_x;
        r_center[1] <= i_center_y;
        r_center[2] <= i_center_z;
        r_extent[0] <= i_extent_x;
        r_extent[1] <= i_extent_y;
        r_extent[2] <= i_extent_z;
    end

    fbc_plane_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_planes    (w_planes)
    );

    fbc_plane_dot #(
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_W       (SUM_W)
    ) u_dot (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (r_vld0),
        .i_center (r_center),
        .i_extent (r_extent),
        .i_planes (w_planes),
        .o_vld    (w_dot_vld),
        .o_sq     (w_sq),
        .o_sums   (w_sums)
    );

    fbc_isqrt_pipe #(
        .OUT_W  (COORD_WIDTH),
        .SIDE_W (SIDE_W)
    ) u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (w_dot_vld),
        .i_radicand (w_sq),
        .i_side     (w_sums),
        .o_vld      (w_sq_vld),
        .o_root     (w_root),
        .o_side     (w_dly_sums)
    );

    // plane passes when sum + leeway * 2^14 is not negative
    always_comb begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            w_tot[p]  = $signed(w_dly_sums[p])
                      + $signed({1'b0, w_root, {NORM_FRAC{1'b0}}});
            w_pass[p] = ~w_tot[p][SUM_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_sq_vld;
        end
        r_visible <= &w_pass;
    end

    assign o_result_valid = r_out_vld;
    assign o_visible      = r_visible;

endmodule
`default_nettype wire
